>>> hdl/sla_pkg.sv
// ----------------------------------------------------------------------------
// Serial line assembler package
// Request codes, register indexes, reset values and the stage control type.
// ----------------------------------------------------------------------------
package sla_pkg;

   localparam int TYPE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 7;
   localparam int LENGTH_W = 8;
   localparam int QCOUNT_W = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [TYPE_W-1:0] REQ_RECEIVE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_POP     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_END = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE    = 2'd2;

   localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'h0a;
   localparam logic [BYTE_W-1:0] ENTER_RESET    = 8'h0d;
   localparam logic [BYTE_W-1:0] ERASE_RESET    = 8'h08;

   // Control carried from the accept stage to the editor stage.
   typedef struct packed {
      logic                pop;
      logic                queued;
      logic                dropping;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
      logic                rd_ok;
      logic                fwd;
   } sla_ctl_type;

endpackage

>>> hdl/serial_line_assembler_unit.sv
// ----------------------------------------------------------------------------
// Serial line assembler unit
// Queues received bytes, edits them into text lines and reads back the line.
// ----------------------------------------------------------------------------
// The unit takes one request every clock cycle while the response is not
// stalled. An accepted request passes the editor stage registers and the
// response register. The acceptance edge updates the receive queue pointers
// and issues the single read of each memory. The edge on which the editor
// stage advances runs the line editor on the popped byte, performs the
// single line store write and loads the response register. Each memory
// sees one read and at most one write per request, which is what sets the
// rate of one request per cycle. A stalled response holds the editor stage
// and, through it, the input. A line store high-water mark stands in for
// clearing the store, so there is no initialisation pass after reset.
module serial_line_assembler_unit #(
   parameter int DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sla_pkg::TYPE_W-1:0]    req_type,
   input  logic [sla_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [sla_pkg::INDEX_W-1:0]   req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_byte_queued,
   output logic                          rsp_dropping,
   output logic                          rsp_line_done,
   output logic [sla_pkg::LENGTH_W-1:0]  rsp_line_length,
   output logic [sla_pkg::BYTE_W-1:0]    rsp_read_data,
   output logic                          rsp_queue_empty,
   output logic [sla_pkg::QCOUNT_W-1:0]  rsp_queue_count,
   input  logic                          csr_we,
   input  logic [sla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sla_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
      logic [AW-1:0] res;
      if (ptr == AW'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   // Configuration registers
   logic [sla_pkg::BYTE_W-1:0] line_end_ff, enter_ff, erase_ff;

   // Receive queue state
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] count_ff, count_in;
   logic          discard_ff, discard_in;

   // Line editor state
   logic [AW-1:0] fill_ff, fill_in;
   logic [HW-1:0] hwm_ff, hwm_in;

   // Memories and their registered read data
   logic [sla_pkg::BYTE_W-1:0] rxq_mem [DEPTH];
   logic [sla_pkg::BYTE_W-1:0] lst_mem [DEPTH];
   logic [sla_pkg::BYTE_W-1:0] rxq_rd_ff;
   logic [sla_pkg::BYTE_W-1:0] lst_rd_ff;

   // Stage registers
   logic                      s1_valid_ff, s1_valid_in;
   sla_pkg::sla_ctl_type      s1_ctl_ff, s1_ctl_in;
   logic [sla_pkg::BYTE_W-1:0] s1_fwd_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_queued_ff, rsp_dropping_ff, rsp_done_ff, rsp_empty_ff;
   logic [sla_pkg::LENGTH_W-1:0] rsp_length_ff;
   logic [sla_pkg::BYTE_W-1:0]   rsp_data_ff;
   logic [sla_pkg::QCOUNT_W-1:0] rsp_count_ff;

   logic accept, out_ready, s1_adv;
   logic push, pop, full;
   logic rd_in_range;
   logic [AW-1:0] rd_addr;

   logic                       ls_we;
   logic [AW-1:0]              ls_waddr;
   logic [sla_pkg::BYTE_W-1:0] ls_wdata;
   logic                       line_done;
   logic [sla_pkg::LENGTH_W-1:0] line_length;
   logic [sla_pkg::BYTE_W-1:0] read_data;

   // Handshake: stage one moves on when the response register is free.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   // Accept stage: queue pointers and discard mode
   always_comb begin
      full       = (count_ff == AW'(DEPTH - 1));
      push       = 1'b0;
      pop        = 1'b0;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      discard_in = discard_ff;
      if (accept) begin
         case (req_type)
            sla_pkg::REQ_RECEIVE: begin
               if (!discard_ff) begin
                  if (!full) begin
                     push = 1'b1;
                  end else begin
                     discard_in = 1'b1;
                  end
               end else if (req_rx_byte == line_end_ff && !full) begin
                  push       = 1'b1;
                  discard_in = 1'b0;
               end
            end
            sla_pkg::REQ_POP: begin
               pop = (count_ff != '0);
            end
            default: begin
            end
         endcase
      end
      if (push) begin
         tail_in  = next_ptr(tail_ff);
         count_in = count_ff + 1'b1;
      end
      if (pop) begin
         head_in  = next_ptr(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   // Editor stage: acts on the popped byte.
   always_comb begin
      fill_in     = fill_ff;
      ls_we       = 1'b0;
      ls_waddr    = fill_ff;
      ls_wdata    = rxq_rd_ff;
      line_done   = 1'b0;
      line_length = '0;
      if (s1_valid_ff && s1_ctl_ff.pop) begin
         if (rxq_rd_ff == erase_ff) begin
            if (fill_ff != '0) begin
               fill_in = fill_ff - 1'b1;
            end
         end else if (rxq_rd_ff != line_end_ff && rxq_rd_ff != enter_ff) begin
            if (fill_ff != AW'(DEPTH - 1)) begin
               ls_we   = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end else begin
            ls_we       = 1'b1;
            ls_wdata    = '0;
            line_done   = 1'b1;
            line_length = sla_pkg::LENGTH_W'({1'b0, fill_ff} + (AW + 1)'(1));
            fill_in     = '0;
         end
      end
      ls_we = ls_we && s1_adv;
      if (!s1_adv) begin
         fill_in = fill_ff;
      end
      // Entries at and above the high-water mark have never been written.
      hwm_in = hwm_ff;
      if (ls_we && HW'(ls_waddr) == hwm_ff) begin
         hwm_in = hwm_ff + 1'b1;
      end
   end

   // Read request decode, with forwarding of a line store write in flight.
   always_comb begin
      rd_addr     = AW'(req_read_index);
      rd_in_range = (32'(req_read_index) < 32'(DEPTH));
      s1_ctl_in.pop      = pop;
      s1_ctl_in.queued   = push;
      s1_ctl_in.dropping = discard_in;
      s1_ctl_in.empty    = (count_in == '0);
      s1_ctl_in.count    = sla_pkg::QCOUNT_W'(count_in);
      s1_ctl_in.rd_ok    = (req_type == sla_pkg::REQ_READ) && rd_in_range &&
                           (32'(req_read_index) < 32'(hwm_in));
      s1_ctl_in.fwd      = s1_ctl_in.rd_ok && ls_we && (ls_waddr == rd_addr);
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      if (s1_ctl_ff.fwd) begin
         read_data = s1_fwd_data_ff;
      end else if (s1_ctl_ff.rd_ok) begin
         read_data = lst_rd_ff;
      end else begin
         read_data = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_end_ff  <= sla_pkg::LINE_END_RESET;
         enter_ff     <= sla_pkg::ENTER_RESET;
         erase_ff     <= sla_pkg::ERASE_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         discard_ff   <= 1'b0;
         fill_ff      <= '0;
         hwm_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sla_pkg::CSR_LINE_END: line_end_ff <= csr_wdata;
               sla_pkg::CSR_ENTER:    enter_ff    <= csr_wdata;
               sla_pkg::CSR_ERASE:    erase_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         discard_ff   <= discard_in;
         fill_ff      <= fill_in;
         hwm_ff       <= hwm_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff      <= s1_ctl_in;
         s1_fwd_data_ff <= ls_wdata;
      end
      if (s1_adv) begin
         rsp_queued_ff   <= s1_ctl_ff.queued;
         rsp_dropping_ff <= s1_ctl_ff.dropping;
         rsp_done_ff     <= line_done;
         rsp_length_ff   <= line_length;
         rsp_data_ff     <= read_data;
         rsp_empty_ff    <= s1_ctl_ff.empty;
         rsp_count_ff    <= s1_ctl_ff.count;
      end
   end

   // Receive queue memory
   always_ff @(posedge clock) begin
      if (push) begin
         rxq_mem[tail_ff] <= req_rx_byte;
      end
      if (accept) begin
         rxq_rd_ff <= rxq_mem[head_ff];
      end
   end

   // Line store memory
   always_ff @(posedge clock) begin
      if (ls_we) begin
         lst_mem[ls_waddr] <= ls_wdata;
      end
      if (accept) begin
         lst_rd_ff <= lst_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_queued = rsp_queued_ff;
   assign rsp_dropping    = rsp_dropping_ff;
   assign rsp_line_done   = rsp_done_ff;
   assign rsp_line_length = rsp_length_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_queue_empty = rsp_empty_ff;
   assign rsp_queue_count = rsp_count_ff;

   // A queued byte raises the fill level by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("receive queue count did not follow a push");

   // The line fill never passes the written region of the line store.
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(hwm_ff))
      else $error("line fill beyond the high-water mark");

   // A request held in the editor stage is neither lost nor replaced.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_ctl_ff)))
      else $error("held editor stage request changed");

endmodule

>>> test/serial_line_assembler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line assembler unit testbench
// Sends receive, pop, read and no-op requests through the valid/stall handshake,
// predicts responses with a behavioural model of the receive queue and line
// editor or takes them from directed rows, and compares each response field by field.
// ----------------------------------------------------------------------------
module serial_line_assembler_unit_tb;

   localparam int DEPTH       = 128;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PRINT_LIMIT = 40;

   localparam logic [sla_pkg::TYPE_W-1:0]    REQ_NOP   = 2'd3;
   localparam logic [sla_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic                         byte_queued;
      logic                         dropping;
      logic                         line_done;
      logic [sla_pkg::LENGTH_W-1:0] line_length;
      logic [sla_pkg::BYTE_W-1:0]   read_data;
      logic                         queue_empty;
      logic [sla_pkg::QCOUNT_W-1:0] queue_count;
   } line_status_type;

   typedef struct {
      logic [sla_pkg::TYPE_W-1:0]  kind;
      logic [sla_pkg::BYTE_W-1:0]  rx_byte;
      logic [sla_pkg::INDEX_W-1:0] index;
      bit                          typed;
      line_status_type             status;
   } stimulus_row_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [sla_pkg::TYPE_W-1:0]    req_type       = sla_pkg::REQ_RECEIVE;
   logic [sla_pkg::BYTE_W-1:0]    req_rx_byte    = '0;
   logic [sla_pkg::INDEX_W-1:0]   req_read_index = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic                          rsp_byte_queued;
   logic                          rsp_dropping;
   logic                          rsp_line_done;
   logic [sla_pkg::LENGTH_W-1:0]  rsp_line_length;
   logic [sla_pkg::BYTE_W-1:0]    rsp_read_data;
   logic                          rsp_queue_empty;
   logic [sla_pkg::QCOUNT_W-1:0]  rsp_queue_count;
   logic                          csr_we         = 1'b0;
   logic [sla_pkg::CSR_IDX_W-1:0] csr_index      = sla_pkg::CSR_LINE_END;
   logic [sla_pkg::BYTE_W-1:0]    csr_wdata      = '0;

   line_status_type rsp_status;
   line_status_type predicted;
   line_status_type pending_status [$];
   stimulus_row_type directed_rows [$];

   // Carried alongside the request so that the monitor knows which rows
   // bring their own expected response.
   bit              row_typed  = 1'b0;
   line_status_type row_status = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   // Behavioural copy of the block state and its registers.
   logic [sla_pkg::BYTE_W-1:0] fifo_mem [DEPTH];
   int unsigned                fifo_rd = 0;
   int unsigned                fifo_wr = 0;
   logic                       discarding = 1'b0;
   logic [sla_pkg::BYTE_W-1:0] line_mem [DEPTH];
   int unsigned                line_len = 0;
   logic [sla_pkg::BYTE_W-1:0] cfg_line_end = sla_pkg::LINE_END_RESET;
   logic [sla_pkg::BYTE_W-1:0] cfg_enter    = sla_pkg::ENTER_RESET;
   logic [sla_pkg::BYTE_W-1:0] cfg_erase    = sla_pkg::ERASE_RESET;

   serial_line_assembler_unit #(.DEPTH(DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_queued(rsp_byte_queued),
      .rsp_dropping   (rsp_dropping),
      .rsp_line_done  (rsp_line_done),
      .rsp_line_length(rsp_line_length),
      .rsp_read_data  (rsp_read_data),
      .rsp_queue_empty(rsp_queue_empty),
      .rsp_queue_count(rsp_queue_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   assign rsp_status = {rsp_byte_queued, rsp_dropping, rsp_line_done, rsp_line_length,
                        rsp_read_data, rsp_queue_empty, rsp_queue_count};

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic int unsigned fifo_fill();
      return (fifo_wr + DEPTH - fifo_rd) % DEPTH;
   endfunction

   function automatic line_status_type assemble_step(
         input logic [sla_pkg::TYPE_W-1:0] kind,
         input logic [sla_pkg::BYTE_W-1:0] rx_byte,
         input logic [sla_pkg::INDEX_W-1:0] index);
      line_status_type s;
      logic [sla_pkg::BYTE_W-1:0] c;
      int unsigned n;
      s = '0;
      case (kind)
         sla_pkg::REQ_RECEIVE: begin
            // In discard mode only a line-end byte that fits is taken, and it ends the mode.
            if (!discarding || rx_byte == cfg_line_end) begin
               if (fifo_fill() < DEPTH - 1) begin
                  fifo_mem[fifo_wr] = rx_byte;
                  fifo_wr = (fifo_wr + 1) % DEPTH;
                  s.byte_queued = 1'b1;
                  discarding = 1'b0;
               end else if (!discarding) begin
                  discarding = 1'b1;
               end
            end
         end
         sla_pkg::REQ_POP: begin
            if (fifo_fill() != 0) begin
               c = fifo_mem[fifo_rd];
               fifo_rd = (fifo_rd + 1) % DEPTH;
               if (c == cfg_erase) begin
                  if (line_len > 0)
                     line_len--;
               end else if (c != cfg_line_end && c != cfg_enter) begin
                  if (line_len < DEPTH - 1) begin
                     line_mem[line_len] = c;
                     line_len++;
                  end
               end else begin
                  line_mem[line_len] = '0;
                  s.line_done = 1'b1;
                  s.line_length = sla_pkg::LENGTH_W'(line_len + 1);
                  line_len = 0;
               end
            end
         end
         sla_pkg::REQ_READ: begin
            s.read_data = line_mem[index];
         end
         default: begin
         end
      endcase
      n = fifo_fill();
      s.dropping = discarding;
      s.queue_empty = (n == 0);
      s.queue_count = sla_pkg::QCOUNT_W'(n);
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t: response %0d, %s: got %0d, want %0d",
                  $time, responses_seen, what, got, want);
      mismatches++;
   endtask

   task automatic check_response(input line_status_type got, input line_status_type want);
      if (got.byte_queued !== want.byte_queued)
         report_mismatch("byte_queued", got.byte_queued, want.byte_queued);
      if (got.dropping !== want.dropping)
         report_mismatch("dropping", got.dropping, want.dropping);
      if (got.line_done !== want.line_done)
         report_mismatch("line_done", got.line_done, want.line_done);
      if (got.line_length !== want.line_length)
         report_mismatch("line_length", got.line_length, want.line_length);
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.queue_empty !== want.queue_empty)
         report_mismatch("queue_empty", got.queue_empty, want.queue_empty);
      if (got.queue_count !== want.queue_count)
         report_mismatch("queue_count", got.queue_count, want.queue_count);
   endtask

   // Responses are checked before the request of the same edge is predicted,
   // since a response always belongs to an older request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_status.size() == 0)
               report_mismatch("response with nothing pending", 1, 0);
            else
               check_response(rsp_status, pending_status.pop_front());
            responses_seen++;
         end
         if (req_valid && !req_stall) begin
            predicted = assemble_step(req_type, req_rx_byte, req_read_index);
            pending_status.push_back(row_typed ? row_status : predicted);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called just after a falling edge; returns just after the falling edge
   // that follows acceptance.
   task automatic issue_request(input logic [sla_pkg::TYPE_W-1:0] kind,
                                input logic [sla_pkg::BYTE_W-1:0] rx_byte,
                                input logic [sla_pkg::INDEX_W-1:0] index,
                                input bit typed, input line_status_type status);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_rx_byte    <= rx_byte;
      req_read_index <= index;
      row_typed      <= typed;
      row_status     <= status;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic receive_byte(input logic [sla_pkg::BYTE_W-1:0] value);
      issue_request(sla_pkg::REQ_RECEIVE, value,
                    sla_pkg::INDEX_W'($urandom_range(0, 127)), 1'b0, '0);
   endtask

   task automatic pop_byte();
      issue_request(sla_pkg::REQ_POP, sla_pkg::BYTE_W'($urandom_range(0, 255)),
                    sla_pkg::INDEX_W'($urandom_range(0, 127)), 1'b0, '0);
   endtask

   task automatic drain_fifo();
      while (fifo_fill() != 0)
         pop_byte();
      pop_byte();
   endtask

   function automatic logic [sla_pkg::BYTE_W-1:0] plain_byte();
      logic [sla_pkg::BYTE_W-1:0] b;
      b = sla_pkg::BYTE_W'($urandom_range(0, 255));
      while (b == cfg_line_end || b == cfg_enter || b == cfg_erase)
         b = sla_pkg::BYTE_W'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic line_sequence();
      int chars;
      int batch;
      int held;
      int i;
      chars = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 12);
      batch = $urandom_range(1, 8);
      held = 0;
      for (i = 0; i < chars; i++) begin
         receive_byte(($urandom_range(0, 5) == 0) ? cfg_erase : plain_byte());
         held++;
         if (held == batch) begin
            repeat (held) pop_byte();
            held = 0;
            batch = $urandom_range(1, 8);
         end
      end
      receive_byte($urandom_range(0, 1) ? cfg_line_end : cfg_enter);
      repeat (held + 1) pop_byte();
   endtask

   task automatic flood_sequence();
      // A few characters already in the line mean the flood runs it past the
      // longest line that can be stored.
      repeat ($urandom_range(2, 6)) begin
         receive_byte(plain_byte());
         pop_byte();
      end
      repeat (DEPTH - 1 + $urandom_range(1, 4)) receive_byte(plain_byte());
      // The queue is still full here, so this line-end byte is lost as well.
      receive_byte(cfg_line_end);
      repeat ($urandom_range(1, 3)) pop_byte();
      receive_byte(cfg_line_end);
      repeat ($urandom_range(0, 2)) receive_byte(plain_byte());
      drain_fifo();
   endtask

   task automatic random_part(input int quota, input bit with_flood);
      int first;
      int pick;
      first = requests_sent;
      if (with_flood)
         flood_sequence();
      while (requests_sent - first < quota) begin
         pick = $urandom_range(0, 39);
         if (pick == 0) begin
            flood_sequence();
         end else if (pick < 19) begin
            line_sequence();
         end else if (pick < 27) begin
            repeat ($urandom_range(1, 4))
               issue_request(sla_pkg::REQ_READ, sla_pkg::BYTE_W'($urandom_range(0, 255)),
                             sla_pkg::INDEX_W'(($urandom_range(0, 3) == 0) ?
                                               $urandom_range(0, 127) :
                                               $urandom_range(0, 15)),
                             1'b0, '0);
         end else if (pick < 33) begin
            drain_fifo();
         end else begin
            repeat ($urandom_range(1, 6))
               issue_request(sla_pkg::TYPE_W'($urandom_range(0, 3)),
                             sla_pkg::BYTE_W'($urandom_range(0, 255)),
                             sla_pkg::INDEX_W'($urandom_range(0, 127)), 1'b0, '0);
         end
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_status.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [sla_pkg::CSR_IDX_W-1:0] index,
                                 input logic [sla_pkg::BYTE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         sla_pkg::CSR_LINE_END: cfg_line_end = value;
         sla_pkg::CSR_ENTER:    cfg_enter = value;
         sla_pkg::CSR_ERASE:    cfg_erase = value;
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic add_row(input logic [sla_pkg::TYPE_W-1:0] kind,
                          input logic [sla_pkg::BYTE_W-1:0] rx_byte,
                          input logic [sla_pkg::INDEX_W-1:0] index, input bit typed,
                          input logic queued, input logic dropping, input logic done,
                          input logic [sla_pkg::LENGTH_W-1:0] length,
                          input logic [sla_pkg::BYTE_W-1:0] rdata,
                          input logic empty, input logic [sla_pkg::QCOUNT_W-1:0] count);
      stimulus_row_type row;
      row.kind = kind;
      row.rx_byte = rx_byte;
      row.index = index;
      row.typed = typed;
      row.status = {queued, dropping, done, length, rdata, empty, count};
      directed_rows.push_back(row);
   endtask

   initial begin
      int i;
      for (i = 0; i < DEPTH; i++)
         line_mem[i] = '0;

      // kind, byte, index, typed, then queued, dropping, done, length, data, empty, count
      add_row(sla_pkg::REQ_READ,    8'h00, 7'd0,   1, 0, 0, 0, 8'd0, 8'h00, 1, 7'd0);
      add_row(sla_pkg::REQ_READ,    8'hff, 7'd127, 1, 0, 0, 0, 8'd0, 8'h00, 1, 7'd0);
      add_row(sla_pkg::REQ_POP,     8'hff, 7'd127, 1, 0, 0, 0, 8'd0, 8'h00, 1, 7'd0);
      add_row(REQ_NOP,              8'hff, 7'd127, 1, 0, 0, 0, 8'd0, 8'h00, 1, 7'd0);
      add_row(sla_pkg::REQ_RECEIVE, 8'h00, 7'd127, 1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd1);
      add_row(sla_pkg::REQ_RECEIVE, 8'hff, 7'd0,   1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd2);
      add_row(sla_pkg::REQ_RECEIVE, sla_pkg::ERASE_RESET,
              7'd85, 1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd3);
      add_row(sla_pkg::REQ_RECEIVE, 8'h41, 7'd42,  1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd4);
      add_row(sla_pkg::REQ_RECEIVE, sla_pkg::ENTER_RESET,
              7'd1, 1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd5);
      add_row(sla_pkg::REQ_RECEIVE, sla_pkg::LINE_END_RESET,
              7'd2, 1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd6);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   1, 0, 0, 0, 8'd0, 8'h00, 0, 7'd5);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   1, 0, 0, 0, 8'd0, 8'h00, 0, 7'd4);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   1, 0, 0, 0, 8'd0, 8'h00, 0, 7'd3);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   1, 0, 0, 0, 8'd0, 8'h00, 0, 7'd2);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   1, 0, 0, 1, 8'd3, 8'h00, 0, 7'd1);
      add_row(sla_pkg::REQ_READ,    8'h5a, 7'd0,   1, 0, 0, 0, 8'd0, 8'h00, 0, 7'd1);
      add_row(sla_pkg::REQ_READ,    8'ha5, 7'd1,   1, 0, 0, 0, 8'd0, 8'h41, 0, 7'd1);
      add_row(sla_pkg::REQ_READ,    8'h00, 7'd2,   1, 0, 0, 0, 8'd0, 8'h00, 0, 7'd1);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   1, 0, 0, 1, 8'd1, 8'h00, 1, 7'd0);
      add_row(sla_pkg::REQ_RECEIVE, sla_pkg::ERASE_RESET,
              7'd0, 1, 1, 0, 0, 8'd0, 8'h00, 0, 7'd1);
      // Erase with an empty line, then an empty line to show nothing was stored.
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   0, 0, 0, 0, 8'd0, 8'h00, 0, 7'd0);
      add_row(sla_pkg::REQ_RECEIVE, sla_pkg::LINE_END_RESET,
              7'd0, 0, 0, 0, 0, 8'd0, 8'h00, 0, 7'd0);
      add_row(sla_pkg::REQ_POP,     8'h00, 7'd0,   0, 0, 0, 0, 8'd0, 8'h00, 0, 7'd0);
      add_row(sla_pkg::REQ_READ,    8'h00, 7'd3,   0, 0, 0, 0, 8'd0, 8'h00, 0, 7'd0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 60;
      for (i = 0; i < directed_rows.size(); i++)
         issue_request(directed_rows[i].kind, directed_rows[i].rx_byte, directed_rows[i].index,
                       directed_rows[i].typed, directed_rows[i].status);
      random_part(300, 1'b1);

      // Erase shares its code with line-end, so erase must win in the editor.
      quiesce();
      write_register(sla_pkg::CSR_LINE_END, 8'h3b);
      write_register(sla_pkg::CSR_ERASE, 8'h3b);
      random_part(60, 1'b0);

      quiesce();
      send_idle_pct = 60;
      recv_idle_pct = 21;
      write_register(sla_pkg::CSR_LINE_END, 8'h00);
      write_register(sla_pkg::CSR_ENTER, 8'hff);
      write_register(sla_pkg::CSR_ERASE, 8'hff);
      write_register(CSR_SPARE, 8'ha5);
      random_part(120, 1'b0);

      quiesce();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(sla_pkg::CSR_LINE_END, 8'hff);
      write_register(sla_pkg::CSR_ENTER, 8'h00);
      write_register(sla_pkg::CSR_ERASE, 8'h00);
      random_part(120, 1'b0);

      quiesce();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
